FILE: src/gge_pkg.sv
// ----------------------------------------------------------------------------
// gge_pkg
// shared types and constants of the grid gradient engine
// ----------------------------------------------------------------------------
package gge_pkg;

    localparam int unsigned DENS_W = 32;
    localparam int unsigned GRAD_W = 33;

    localparam logic [2:0] REG_ACTIVE_DIMS = 3'd0;
    localparam logic [2:0] REG_SIZE_X      = 3'd1;
    localparam logic [2:0] REG_SIZE_Y      = 3'd2;
    localparam logic [2:0] REG_SIZE_Z      = 3'd3;
    localparam logic [2:0] REG_SUBSTRATES  = 3'd4;
    localparam logic [2:0] REG_WIDTH_X     = 3'd5;
    localparam logic [2:0] REG_WIDTH_Y     = 3'd6;
    localparam logic [2:0] REG_WIDTH_Z     = 3'd7;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RD_UP,
        ST_RD_DN,
        ST_CAP_DN,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_NEXT_AXIS,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       load;
        logic       wr_en;
        logic       rd_up;
        logic       rd_dn;
        logic       cap_up;
        logic       cap_dn;
        logic       div_start;
        logic [1:0] axis;
        logic       store_grad;
        logic       out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       err;
        logic       is_query;
        logic [1:0] dims;
        logic       div_done;
    } t_status;

endpackage

FILE: src/gge_ram.sv
// ----------------------------------------------------------------------------
// gge_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module gge_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/gge_div.sv
// ----------------------------------------------------------------------------
// gge_div
// restoring divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module gge_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_dividend,
    input  logic [16:0] i_divisor,
    output logic [32:0] o_quotient,
    output logic        o_done
);
    logic [32:0] r_rem_q;
    logic [17:0] r_rem;
    logic [16:0] r_div;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [17:0] w_trial;
    logic [17:0] w_sub;
    logic [32:0] w_mag;

    assign w_mag   = i_dividend[32] ? (33'd0 - i_dividend) : i_dividend;
    assign w_trial = {r_rem[16:0], r_rem_q[32]};
    assign w_sub   = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd33;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem_q <= w_mag;
            r_rem   <= 18'd0;
            r_div   <= i_divisor;
            r_neg   <= i_dividend[32];
        end else if (r_busy) begin
            if (!w_sub[17]) begin
                r_rem   <= w_sub;
                r_rem_q <= {r_rem_q[31:0], 1'b1};
            end else begin
                r_rem   <= w_trial;
                r_rem_q <= {r_rem_q[31:0], 1'b0};
            end
        end
    end

    assign o_quotient = r_neg ? (33'd0 - r_rem_q) : r_rem_q;
    assign o_done     = r_done;
endmodule

FILE: src/gge_ctrl.sv
// ----------------------------------------------------------------------------
// gge_ctrl
// sequencer: store write, or per-axis neighbor reads and divide; result hand-off
// ----------------------------------------------------------------------------
module gge_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  gge_pkg::t_status i_status,
    output gge_pkg::t_cmd   o_cmd
);
    gge_pkg::t_state r_state, n_state;
    logic [1:0]      r_axis, n_axis;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gge_pkg::ST_IDLE;
            r_axis      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.axis  = r_axis;
        o_in_stall  = 1'b1;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            gge_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = gge_pkg::ST_CHECK;
                end
            end
            gge_pkg::ST_CHECK: begin
                n_axis = 2'd0;
                if (i_status.err || !i_status.is_query) begin
                    o_cmd.wr_en = !i_status.err;
                    n_state     = gge_pkg::ST_OUT;
                end else begin
                    n_state = gge_pkg::ST_RD_UP;
                end
            end
            gge_pkg::ST_RD_UP: begin
                o_cmd.rd_up = 1'b1;
                n_state     = gge_pkg::ST_RD_DN;
            end
            gge_pkg::ST_RD_DN: begin
                o_cmd.rd_dn  = 1'b1;
                o_cmd.cap_up = 1'b1;
                n_state      = gge_pkg::ST_CAP_DN;
            end
            gge_pkg::ST_CAP_DN: begin
                o_cmd.cap_dn = 1'b1;
                n_state      = gge_pkg::ST_DIV_START;
            end
            gge_pkg::ST_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = gge_pkg::ST_DIV_WAIT;
            end
            gge_pkg::ST_DIV_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.store_grad = 1'b1;
                    n_state          = gge_pkg::ST_NEXT_AXIS;
                end
            end
            gge_pkg::ST_NEXT_AXIS: begin
                if ({1'b0, r_axis} + 3'd1 < {1'b0, i_status.dims}) begin
                    n_axis  = r_axis + 2'd1;
                    n_state = gge_pkg::ST_RD_UP;
                end else begin
                    n_state = gge_pkg::ST_OUT;
                end
            end
            gge_pkg::ST_OUT: begin
                // result register is reloaded once it is empty or its result is taken in the same cycle
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = gge_pkg::ST_IDLE;
                end
            end
            default: n_state = gge_pkg::ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
endmodule

FILE: src/gge_dp.sv
// ----------------------------------------------------------------------------
// gge_dp
// datapath: config registers, request latch, address gen, density store,
// difference and divide, result register
// ----------------------------------------------------------------------------
module gge_dp #(
    parameter int unsigned MAX_X          = 16,
    parameter int unsigned MAX_Y          = 16,
    parameter int unsigned MAX_Z          = 16,
    parameter int unsigned MAX_SUBSTRATES = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data,
    input  logic             i_operation,
    input  logic [1:0]       i_substrate,
    input  logic [3:0]       i_coord_x,
    input  logic [3:0]       i_coord_y,
    input  logic [3:0]       i_coord_z,
    input  logic [31:0]      i_density,
    input  gge_pkg::t_cmd    i_cmd,
    output gge_pkg::t_status o_status,
    output logic [32:0]      o_grad_x,
    output logic [32:0]      o_grad_y,
    output logic [32:0]      o_grad_z,
    output logic             o_range_error
);
    localparam int unsigned XW    = (MAX_X > 1) ? $clog2(MAX_X) : 1;
    localparam int unsigned YW    = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
    localparam int unsigned ZW    = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
    localparam int unsigned SW    = (MAX_SUBSTRATES > 1) ? $clog2(MAX_SUBSTRATES) : 1;
    localparam int unsigned DEPTH = MAX_SUBSTRATES * MAX_Z * MAX_Y * MAX_X;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] STRIDE_Y = AW'(MAX_X);
    localparam logic [AW-1:0] STRIDE_Z = AW'(MAX_X * MAX_Y);

    logic [1:0]  r_active_dims;
    logic [4:0]  r_size_x, r_size_y, r_size_z;
    logic [2:0]  r_sub_cnt;
    logic [15:0] r_width_x, r_width_y, r_width_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_dims <= 2'd1;
            r_size_x      <= 5'd16;
            r_size_y      <= 5'd16;
            r_size_z      <= 5'd16;
            r_sub_cnt     <= 3'd1;
            r_width_x     <= 16'd1;
            r_width_y     <= 16'd1;
            r_width_z     <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gge_pkg::REG_ACTIVE_DIMS: r_active_dims <= i_cfg_data[1:0];
                gge_pkg::REG_SIZE_X:      r_size_x      <= i_cfg_data[4:0];
                gge_pkg::REG_SIZE_Y:      r_size_y      <= i_cfg_data[4:0];
                gge_pkg::REG_SIZE_Z:      r_size_z      <= i_cfg_data[4:0];
                gge_pkg::REG_SUBSTRATES:  r_sub_cnt     <= i_cfg_data[2:0];
                gge_pkg::REG_WIDTH_X:     r_width_x     <= i_cfg_data;
                gge_pkg::REG_WIDTH_Y:     r_width_y     <= i_cfg_data;
                gge_pkg::REG_WIDTH_Z:     r_width_z     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective (clamped) configuration
    logic [1:0]  w_dims;
    logic [8:0]  w_nx, w_ny, w_nz, w_ns;
    assign w_dims = (r_active_dims == 2'd0) ? 2'd1 : r_active_dims;

    function automatic logic [8:0] clamp(input logic [4:0] v, input logic [8:0] mx);
        logic [8:0] e;
        e = {4'd0, v};
        if (e == 9'd0) return 9'd1;
        return (e > mx) ? mx : e;
    endfunction

    assign w_nx = clamp(r_size_x, 9'(MAX_X));
    assign w_ny = clamp(r_size_y, 9'(MAX_Y));
    assign w_nz = clamp(r_size_z, 9'(MAX_Z));
    assign w_ns = clamp({2'd0, r_sub_cnt}, 9'(MAX_SUBSTRATES));

    // request latch
    logic        r_op;
    logic [1:0]  r_s;
    logic [3:0]  r_x, r_y, r_z;
    logic [31:0] r_dens;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_operation;
            r_s    <= i_substrate;
            r_x    <= i_coord_x;
            r_y    <= (w_dims >= 2'd2) ? i_coord_y : 4'd0;
            r_z    <= (w_dims == 2'd3) ? i_coord_z : 4'd0;
            r_dens <= i_density;
        end
    end

    logic w_err;
    assign w_err = ({7'd0, r_s} >= w_ns) || ({5'd0, r_x} >= w_nx)
                || (w_dims >= 2'd2 && {5'd0, r_y} >= w_ny)
                || (w_dims == 2'd3 && {5'd0, r_z} >= w_nz);

    logic [AW-1:0] w_base;
    assign w_base = AW'((((SW'(r_s) * MAX_Z) + ZW'(r_z)) * MAX_Y + YW'(r_y)) * MAX_X
                        + XW'(r_x));

    // selected axis
    logic [3:0]    w_pos;
    logic [8:0]    w_n;
    logic [AW-1:0] w_stride;
    logic [15:0]   w_width;
    always_comb begin
        case (i_cmd.axis)
            2'd1: begin
                w_pos = r_y; w_n = w_ny; w_stride = STRIDE_Y; w_width = r_width_y;
            end
            2'd2: begin
                w_pos = r_z; w_n = w_nz; w_stride = STRIDE_Z; w_width = r_width_z;
            end
            default: begin
                w_pos = r_x; w_n = w_nx; w_stride = AW'(1); w_width = r_width_x;
            end
        endcase
    end

    logic w_low, w_high;
    assign w_low  = (w_pos == 4'd0);
    assign w_high = ({5'd0, w_pos} == w_n - 9'd1);

    logic [AW-1:0] w_addr;
    always_comb begin
        if (i_cmd.rd_up) begin
            w_addr = w_high ? w_base : w_base + w_stride;
        end else if (i_cmd.rd_dn) begin
            w_addr = w_low ? w_base : w_base - w_stride;
        end else begin
            w_addr = w_base;
        end
    end

    logic [31:0] w_rdata;
    gge_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_addr  (w_addr),
        .i_wdata (r_dens),
        .o_rdata (w_rdata)
    );

    logic [31:0] r_up;
    logic [32:0] r_diff;
    logic [16:0] r_divisor;
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_up) r_up <= w_rdata;
        if (i_cmd.cap_dn) begin
            r_diff    <= {r_up[31], r_up} - {w_rdata[31], w_rdata};
            r_divisor <= ((w_low || w_high) ? 17'd0 : {1'b0, (w_width == 16'd0) ?
                          16'd1 : w_width}) + {1'b0, (w_width == 16'd0) ? 16'd1 : w_width};
        end
    end

    logic [32:0] w_quot;
    logic        w_div_done;
    gge_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_diff),
        .i_divisor  (r_divisor),
        .o_quotient (w_quot),
        .o_done     (w_div_done)
    );

    logic [32:0] r_gx, r_gy, r_gz;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_gx <= '0;
            r_gy <= '0;
            r_gz <= '0;
        end else if (i_cmd.store_grad) begin
            case (i_cmd.axis)
                2'd1:    r_gy <= w_quot;
                2'd2:    r_gz <= w_quot;
                default: r_gx <= w_quot;
            endcase
        end
    end

    logic [32:0] r_ox, r_oy, r_oz;
    logic        r_oerr;
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ox   <= w_err ? 33'd0 : r_gx;
            r_oy   <= w_err ? 33'd0 : r_gy;
            r_oz   <= w_err ? 33'd0 : r_gz;
            r_oerr <= w_err;
        end
    end

    assign o_status.err      = w_err;
    assign o_status.is_query = (r_op == gge_pkg::OP_QUERY);
    assign o_status.dims     = w_dims;
    assign o_status.div_done = w_div_done;
    assign o_grad_x          = r_ox;
    assign o_grad_y          = r_oy;
    assign o_grad_z          = r_oz;
    assign o_range_error     = r_oerr;
endmodule

FILE: src/grid_gradient_engine.sv
// ----------------------------------------------------------------------------
// grid_gradient_engine
// central-difference gradient over a multi-substrate 3d density grid
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_stall) carries write or query requests;
//   output channel (o_out_valid / i_out_stall) returns one result per request.
//   config port writes registers 0..7; the user must write them only while the
//   block is idle, which the block itself does not enforce.
// sequence: a write or out-of-range request is checked, then goes to the result
//   register; a query does, per active axis, two store reads plus a divide,
//   with the divider producing one quotient bit per cycle.
// throughput: one request at a time; the next request is accepted once the
//   previous one has been moved to the result register.
// reset: synchronous, active low; control and config registers return to reset
//   values, store contents are undefined until written.
// stall: a stalled result holds in the output register; the block may take
//   and process one more request meanwhile.
// ----------------------------------------------------------------------------
module grid_gradient_engine #(
    parameter int unsigned MAX_X          = 16,
    parameter int unsigned MAX_Y          = 16,
    parameter int unsigned MAX_Z          = 16,
    parameter int unsigned MAX_SUBSTRATES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [1:0]  i_substrate,
    input  logic [3:0]  i_coord_x,
    input  logic [3:0]  i_coord_y,
    input  logic [3:0]  i_coord_z,
    input  logic [31:0] i_density,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [32:0] o_grad_x,
    output logic [32:0] o_grad_y,
    output logic [32:0] o_grad_z,
    output logic        o_range_error
);
    gge_pkg::t_cmd    w_cmd;
    gge_pkg::t_status w_status;

    gge_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    gge_dp #(
        .MAX_X          (MAX_X),
        .MAX_Y          (MAX_Y),
        .MAX_Z          (MAX_Z),
        .MAX_SUBSTRATES (MAX_SUBSTRATES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_operation   (i_operation),
        .i_substrate   (i_substrate),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_density     (i_density),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_grad_x      (o_grad_x),
        .o_grad_y      (o_grad_y),
        .o_grad_z      (o_grad_z),
        .o_range_error (o_range_error)
    );
endmodule

FILE: src/gge_checker.sv
// ----------------------------------------------------------------------------
// gge_checker
// port-level checks of the grid gradient engine
// ----------------------------------------------------------------------------
module gge_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [32:0] o_grad_x,
    input logic [32:0] o_grad_y,
    input logic [32:0] o_grad_z,
    input logic        o_range_error
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_grad_x))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_range_error |-> o_grad_x == 33'd0 && o_grad_y == 33'd0
        && o_grad_z == 33'd0)
        else $error("error result carries gradient");

    a_accept_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while busy");

    a_no_out_at_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
endmodule

bind grid_gradient_engine gge_checker u_gge_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_grad_x      (o_grad_x),
    .o_grad_y      (o_grad_y),
    .o_grad_z      (o_grad_z),
    .o_range_error (o_range_error)
);
